@@ src/ffba_pkg.sv @@
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF   = 16;
    localparam int NUM_REGIONS_DEF  = 4;
    localparam int REGION_BYTES_DEF = 65536;

    localparam int SIZE_W  = 17;
    localparam int OFF_W   = 16;
    localparam int LEN_W   = 17;
    localparam int PLEN_W  = 18;
    localparam int TAG_W   = 64;
    localparam int FREE_W  = 19;
    localparam int RGN_W   = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_GROW    = 2'd2;
    localparam logic [1:0] OP_IDENT   = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd2;

    localparam logic [1:0] REG_SIZE_A = 2'd0;
    localparam logic [1:0] REG_SIZE_B = 2'd1;
    localparam logic [1:0] REG_SIZE_C = 2'd2;
    localparam logic [1:0] REG_SIZE_D = 2'd3;

    localparam logic [1:0] LAST_REGION = 2'd3;

    localparam logic [4:0] DO_NONE         = 5'd0;
    localparam logic [4:0] DO_ACCEPT       = 5'd1;
    localparam logic [4:0] DO_FAIL_SPACE   = 5'd2;
    localparam logic [4:0] DO_FAIL_MATCH   = 5'd3;
    localparam logic [4:0] DO_READ_IDX     = 5'd4;
    localparam logic [4:0] DO_STEP_IDX     = 5'd5;
    localparam logic [4:0] DO_MATCH_CAP    = 5'd6;
    localparam logic [4:0] DO_LIM_CAP      = 5'd7;
    localparam logic [4:0] DO_GROW_INPLACE = 5'd8;
    localparam logic [4:0] DO_FP_INIT      = 5'd9;
    localparam logic [4:0] DO_FP_NEXT_RGN  = 5'd10;
    localparam logic [4:0] DO_FP_ADVANCE   = 5'd11;
    localparam logic [4:0] DO_FP_FOUND     = 5'd12;
    localparam logic [4:0] DO_REL_SETUP    = 5'd13;
    localparam logic [4:0] DO_SH_READ      = 5'd14;
    localparam logic [4:0] DO_SH_WRITE     = 5'd15;
    localparam logic [4:0] DO_SH_FINAL     = 5'd16;
    localparam logic [4:0] DO_OUTPUT       = 5'd17;

    typedef struct packed {
        logic [RGN_W-1:0] region;
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic [TAG_W-1:0] owner;
        logic [TAG_W-1:0] thread;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [4:0] uop;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       at_end;
        logic       match;
        logic       fp_other;
        logic       fp_fit;
        logic       cr_last;
        logic       grow_fits;
        logic       full;
        logic       req_zero;
        logic       sh_done;
        logic       out_free;
    } dp_stat_t;

endpackage

@@ src/ffba_ram.sv @@
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/ffba_ctrl.sv @@
module ffba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffba_pkg::dp_stat_t stat,
    output ffba_pkg::cmd_t    cmd
);
    import ffba_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_FM_RD  = 4'd2;
    localparam logic [3:0] S_FM_EV  = 4'd3;
    localparam logic [3:0] S_LIM_RD = 4'd4;
    localparam logic [3:0] S_LIM_EV = 4'd5;
    localparam logic [3:0] S_GR_DEC = 4'd6;
    localparam logic [3:0] S_FP_RD  = 4'd7;
    localparam logic [3:0] S_FP_EV  = 4'd8;
    localparam logic [3:0] S_SH     = 4'd9;
    localparam logic [3:0] S_SH_WR  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.uop    = DO_NONE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.uop    = DO_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op)
                    OP_IDENT: state_next = S_OUT;
                    OP_ALLOC:
                    begin
                        if (stat.req_zero || stat.full)
                        begin
                            cmd.uop    = DO_FAIL_SPACE;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.uop    = DO_FP_INIT;
                            state_next = S_FP_RD;
                        end
                    end
                    default: state_next = S_FM_RD;
                endcase
            end
            S_FM_RD:
            begin
                if (stat.at_end)
                begin
                    cmd.uop    = DO_FAIL_MATCH;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.uop    = DO_READ_IDX;
                    state_next = S_FM_EV;
                end
            end
            S_FM_EV:
            begin
                if (stat.match)
                begin
                    if (stat.op == OP_RELEASE)
                    begin
                        cmd.uop    = DO_REL_SETUP;
                        state_next = S_SH;
                    end
                    else
                    begin
                        cmd.uop    = DO_MATCH_CAP;
                        state_next = S_LIM_RD;
                    end
                end
                else
                begin
                    cmd.uop    = DO_STEP_IDX;
                    state_next = S_FM_RD;
                end
            end
            S_LIM_RD:
            begin
                if (stat.at_end)
                begin
                    state_next = S_GR_DEC;
                end
                else
                begin
                    cmd.uop    = DO_READ_IDX;
                    state_next = S_LIM_EV;
                end
            end
            S_LIM_EV:
            begin
                cmd.uop    = DO_LIM_CAP;
                state_next = S_GR_DEC;
            end
            S_GR_DEC:
            begin
                if (stat.grow_fits)
                begin
                    cmd.uop    = DO_GROW_INPLACE;
                    state_next = S_OUT;
                end
                else if (stat.full)
                begin
                    cmd.uop    = DO_FAIL_SPACE;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.uop    = DO_FP_INIT;
                    state_next = S_FP_RD;
                end
            end
            S_FP_RD:
            begin
                if (!stat.at_end)
                begin
                    cmd.uop = DO_READ_IDX;
                end
                state_next = S_FP_EV;
            end
            S_FP_EV:
            begin
                if (stat.fp_fit)
                begin
                    cmd.uop    = DO_FP_FOUND;
                    state_next = S_SH;
                end
                else if (stat.fp_other)
                begin
                    if (stat.cr_last)
                    begin
                        cmd.uop    = DO_FAIL_SPACE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.uop = DO_FP_NEXT_RGN;
                    end
                end
                else
                begin
                    cmd.uop    = DO_FP_ADVANCE;
                    state_next = S_FP_RD;
                end
            end
            S_SH:
            begin
                if (stat.sh_done)
                begin
                    cmd.uop    = DO_SH_FINAL;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.uop    = DO_SH_READ;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.uop    = DO_SH_WRITE;
                state_next = S_SH;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.uop    = DO_OUTPUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ src/ffba_dp.sv @@
module ffba_dp #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int NUM_REGIONS  = ffba_pkg::NUM_REGIONS_DEF,
    parameter int REGION_BYTES = ffba_pkg::REGION_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffba_pkg::cmd_t                cmd,
    output ffba_pkg::dp_stat_t            stat,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffba_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffba_pkg::PDATA_W-1:0]  prdata,
    input  logic [1:0]                    opcode,
    input  logic [ffba_pkg::SIZE_W-1:0]   request_bytes,
    input  logic [ffba_pkg::TAG_W-1:0]    owner_tag,
    input  logic [ffba_pkg::TAG_W-1:0]    thread_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [ffba_pkg::RGN_W-1:0]    block_region,
    output logic [ffba_pkg::OFF_W-1:0]    block_offset,
    output logic [ffba_pkg::TAG_W-1:0]    new_identifier,
    output logic [ffba_pkg::FREE_W-1:0]   free_bytes
);
    import ffba_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam logic [SIZE_W-1:0] RB_LIM = SIZE_W'(REGION_BYTES);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BLOCKS);

    logic [SIZE_W-1:0] size_reg [4];
    logic [SIZE_W-1:0] lim_arr [4];
    logic [FREE_W-1:0] cap;

    logic [1:0]        op_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [TAG_W-1:0]  owner_reg;
    logic [TAG_W-1:0]  thread_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     m_reg;
    logic [RGN_W-1:0]  mreg_reg;
    logic [OFF_W-1:0]  mstart_reg;
    logic [LEN_W-1:0]  mlen_reg;
    logic [SIZE_W-1:0] lim_reg;
    logic [PLEN_W-1:0] len_reg;
    logic [RGN_W-1:0]  cr_reg;
    logic [SIZE_W-1:0] p_reg;
    logic [RGN_W-1:0]  nreg_reg;
    logic [OFF_W-1:0]  noff_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     stop_reg;
    logic              up_reg;
    logic              wr_new_reg;
    logic [1:0]        st_reg;
    logic [RGN_W-1:0]  rres_reg;
    logic [OFF_W-1:0]  ores_reg;
    logic [TAG_W-1:0]  counter_reg;
    logic [FREE_W-1:0] used_reg;

    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [RGN_W-1:0]  out_region_reg;
    logic [OFF_W-1:0]  out_offset_reg;
    logic [TAG_W-1:0]  out_ident_reg;
    logic [FREE_W-1:0] out_free_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_e;

    logic [SIZE_W-1:0] lim_cr;
    logic [FREE_W-1:0] pl;
    logic [FREE_W-1:0] grow_end;
    logic              cfg_wr;
    logic [CW-1:0]     j_src;

    assign rd_e   = entry_t'(ram_rdata);
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cap = '0;
        for (int r = 0; r < 4; r++)
        begin
            if (r < NUM_REGIONS)
            begin
                lim_arr[r] = (size_reg[r] > RB_LIM) ? RB_LIM : size_reg[r];
            end
            else
            begin
                lim_arr[r] = '0;
            end
            cap = cap + FREE_W'(lim_arr[r]);
        end
    end

    assign prdata = {{(PDATA_W - SIZE_W){1'b0}}, size_reg[paddr[3:2]]};

    assign lim_cr   = lim_arr[cr_reg];
    assign pl       = FREE_W'(p_reg) + FREE_W'(len_reg);
    assign grow_end = FREE_W'(mstart_reg) + FREE_W'(mlen_reg) + FREE_W'(req_reg);
    assign j_src    = up_reg ? (j_reg - CW'(1)) : (j_reg + CW'(1));

    always_comb
    begin
        stat.op        = op_reg;
        stat.at_end    = (idx_reg == count_reg);
        stat.match     = (rd_e.owner == owner_reg) && (rd_e.thread == thread_reg);
        stat.fp_other  = stat.at_end || (rd_e.region != cr_reg);
        stat.fp_fit    = (lim_cr != '0) && (pl <= FREE_W'(lim_cr))
                         && (stat.fp_other || (pl <= FREE_W'(rd_e.start)));
        stat.cr_last   = (cr_reg == LAST_REGION);
        stat.grow_fits = (req_reg == '0) || (grow_end <= FREE_W'(lim_reg));
        stat.full      = (count_reg == FULL_CNT);
        stat.req_zero  = (req_reg == '0);
        stat.sh_done   = (j_reg == stop_reg);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = j_reg[AW-1:0];
        ram_wdata = rd_e;
        ram_re    = 1'b0;
        ram_raddr = idx_reg[AW-1:0];
        case (cmd.uop)
            DO_READ_IDX:
            begin
                ram_re = 1'b1;
            end
            DO_SH_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = j_src[AW-1:0];
            end
            DO_SH_WRITE:
            begin
                ram_we = 1'b1;
            end
            DO_SH_FINAL:
            begin
                ram_we    = wr_new_reg;
                ram_wdata = '{region: nreg_reg, start: noff_reg, length: len_reg[LEN_W-1:0],
                              owner: owner_reg, thread: thread_reg};
            end
            DO_GROW_INPLACE:
            begin
                ram_we    = 1'b1;
                ram_waddr = m_reg[AW-1:0];
                ram_wdata = '{region: mreg_reg, start: mstart_reg,
                              length: mlen_reg + req_reg,
                              owner: owner_reg, thread: thread_reg};
            end
            default: ram_we = 1'b0;
        endcase
    end

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg[REG_SIZE_A] <= SIZE_W'(65536);
            size_reg[REG_SIZE_B] <= '0;
            size_reg[REG_SIZE_C] <= '0;
            size_reg[REG_SIZE_D] <= '0;
            count_reg     <= '0;
            counter_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                size_reg[paddr[3:2]] <= pwdata[SIZE_W-1:0];
            end
            if (cmd.uop == DO_OUTPUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.uop)
                DO_ACCEPT:
                begin
                    if (opcode == OP_IDENT)
                    begin
                        counter_reg <= counter_reg + TAG_W'(1);
                    end
                end
                DO_GROW_INPLACE:
                begin
                    used_reg <= used_reg + FREE_W'(req_reg);
                end
                DO_FP_FOUND:
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        count_reg <= count_reg + CW'(1);
                        used_reg  <= used_reg + FREE_W'(len_reg);
                    end
                    else
                    begin
                        used_reg <= used_reg + FREE_W'(req_reg);
                    end
                end
                DO_REL_SETUP:
                begin
                    count_reg <= count_reg - CW'(1);
                    used_reg  <= used_reg - FREE_W'(rd_e.length);
                end
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.uop)
            DO_ACCEPT:
            begin
                op_reg     <= opcode;
                req_reg    <= request_bytes;
                owner_reg  <= owner_tag;
                thread_reg <= thread_tag;
                len_reg    <= PLEN_W'(request_bytes);
                idx_reg    <= '0;
                st_reg     <= STATUS_OK;
                rres_reg   <= '0;
                ores_reg   <= '0;
            end
            DO_FAIL_SPACE:
            begin
                st_reg   <= STATUS_NO_SPACE;
                rres_reg <= '0;
                ores_reg <= '0;
            end
            DO_FAIL_MATCH:
            begin
                st_reg <= STATUS_NO_MATCH;
            end
            DO_STEP_IDX:
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            DO_MATCH_CAP:
            begin
                m_reg      <= idx_reg;
                mreg_reg   <= rd_e.region;
                mstart_reg <= rd_e.start;
                mlen_reg   <= rd_e.length;
                lim_reg    <= lim_arr[rd_e.region];
                idx_reg    <= idx_reg + CW'(1);
            end
            DO_LIM_CAP:
            begin
                if ((rd_e.region == mreg_reg) && (SIZE_W'(rd_e.start) < lim_reg))
                begin
                    lim_reg <= SIZE_W'(rd_e.start);
                end
            end
            DO_GROW_INPLACE:
            begin
                rres_reg <= mreg_reg;
                ores_reg <= mstart_reg;
            end
            DO_FP_INIT:
            begin
                idx_reg <= '0;
                cr_reg  <= '0;
                p_reg   <= '0;
                if (op_reg == OP_GROW)
                begin
                    len_reg <= PLEN_W'(mlen_reg) + PLEN_W'(req_reg);
                end
            end
            DO_FP_NEXT_RGN:
            begin
                cr_reg <= cr_reg + RGN_W'(1);
                p_reg  <= '0;
            end
            DO_FP_ADVANCE:
            begin
                p_reg   <= SIZE_W'(rd_e.start) + rd_e.length;
                idx_reg <= idx_reg + CW'(1);
            end
            DO_FP_FOUND:
            begin
                nreg_reg   <= cr_reg;
                noff_reg   <= p_reg[OFF_W-1:0];
                rres_reg   <= cr_reg;
                ores_reg   <= p_reg[OFF_W-1:0];
                wr_new_reg <= 1'b1;
                if (op_reg == OP_ALLOC)
                begin
                    up_reg   <= 1'b1;
                    j_reg    <= count_reg;
                    stop_reg <= idx_reg;
                end
                else if (idx_reg <= m_reg)
                begin
                    up_reg   <= 1'b1;
                    j_reg    <= m_reg;
                    stop_reg <= idx_reg;
                end
                else
                begin
                    up_reg   <= 1'b0;
                    j_reg    <= m_reg;
                    stop_reg <= idx_reg - CW'(1);
                end
            end
            DO_REL_SETUP:
            begin
                up_reg     <= 1'b0;
                wr_new_reg <= 1'b0;
                j_reg      <= idx_reg;
                stop_reg   <= count_reg - CW'(1);
            end
            DO_SH_WRITE:
            begin
                j_reg <= j_src;
            end
            DO_OUTPUT:
            begin
                out_status_reg <= st_reg;
                out_region_reg <= rres_reg;
                out_offset_reg <= ores_reg;
                out_ident_reg  <= (op_reg == OP_IDENT) ? counter_reg : '0;
                out_free_reg   <= (cap > used_reg) ? (cap - used_reg) : '0;
            end
            default: op_reg <= op_reg;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign block_region   = out_region_reg;
    assign block_offset   = out_offset_reg;
    assign new_identifier = out_ident_reg;
    assign free_bytes     = out_free_reg;

endmodule

@@ src/first_fit_block_allocator_core.sv @@
// First-fit block allocator.
// Input channel (in_valid/in_ready) carries one request transaction: opcode,
// request_bytes, owner_tag, thread_tag. Output channel (out_valid/out_ready)
// returns exactly one result transaction per request: status, block_region,
// block_offset, new_identifier, free_bytes.
// Region sizes are written through the APB port (byte addresses 0, 4, 8, 12);
// write them only while no request is outstanding.
// One request is worked at a time. The block table lives in a RAM with a
// registered read, so each table entry visited takes a read state and an
// evaluate state. Get-identifier goes straight from dispatch to output, and
// inserting or removing a block adds a read and a write state per entry
// moved. in_ready is high again in the cycle the result appears.
// Reset empties the table, clears the identifier counter and sets the region
// sizes to 65536, 0, 0, 0; no clearing pass is needed.
// The result waits in an output register; if the receiver stalls, the
// finished request holds there and the next request can be taken and worked
// until its own result is ready to load.
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int NUM_REGIONS  = ffba_pkg::NUM_REGIONS_DEF,
    parameter int REGION_BYTES = ffba_pkg::REGION_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffba_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffba_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [ffba_pkg::SIZE_W-1:0]   request_bytes,
    input  logic [ffba_pkg::TAG_W-1:0]    owner_tag,
    input  logic [ffba_pkg::TAG_W-1:0]    thread_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [ffba_pkg::RGN_W-1:0]    block_region,
    output logic [ffba_pkg::OFF_W-1:0]    block_offset,
    output logic [ffba_pkg::TAG_W-1:0]    new_identifier,
    output logic [ffba_pkg::FREE_W-1:0]   free_bytes
);
    import ffba_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    assign pready = 1'b1;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .NUM_REGIONS  (NUM_REGIONS),
        .REGION_BYTES (REGION_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .opcode         (opcode),
        .request_bytes  (request_bytes),
        .owner_tag      (owner_tag),
        .thread_tag     (thread_tag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .block_region   (block_region),
        .block_offset   (block_offset),
        .new_identifier (new_identifier),
        .free_bytes     (free_bytes)
    );

endmodule

@@ src/ffba_checker.sv @@
module ffba_props (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    status,
    input logic [ffba_pkg::RGN_W-1:0]    block_region,
    input logic [ffba_pkg::OFF_W-1:0]    block_offset,
    input logic [ffba_pkg::TAG_W-1:0]    new_identifier
);
    import ffba_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(block_offset))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> (block_region == '0) && (block_offset == '0)
            && (new_identifier == '0))
        else $error("failed result carries placement");

    a_ident_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (new_identifier != '0) |-> (status == STATUS_OK)
            && (block_region == '0) && (block_offset == '0))
        else $error("identifier result carries placement");

    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

endmodule

bind first_fit_block_allocator_core ffba_props u_ffba_props (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .block_region   (block_region),
    .block_offset   (block_offset),
    .new_identifier (new_identifier)
);

@@ bench/ffba_checker.sv @@
module ffba_checker
    import ffba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [SIZE_W-1:0]  request_bytes,
    input  logic [TAG_W-1:0]   owner_tag,
    input  logic [TAG_W-1:0]   thread_tag,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic [RGN_W-1:0]   block_region,
    input  logic [OFF_W-1:0]   block_offset,
    input  logic [TAG_W-1:0]   new_identifier,
    input  logic [FREE_W-1:0]  free_bytes,
    output int                 mismatches,
    output int                 pending,
    output int                 results_seen
);

    localparam int SLOTS = MAX_BLOCKS_DEF;
    localparam int RGN_MAX = REGION_BYTES_DEF;

    typedef struct {
        logic [1:0]        st;
        logic [RGN_W-1:0]  rgn;
        logic [OFF_W-1:0]  off;
        logic [TAG_W-1:0]  ident;
        logic [FREE_W-1:0] free;
    } outcome_t;

    outcome_t  expected_q[$];

    bit         blk_valid [SLOTS];
    int         blk_region[SLOTS];
    int         blk_start [SLOTS];
    int         blk_len   [SLOTS];
    logic [63:0] blk_owner [SLOTS];
    logic [63:0] blk_thread[SLOTS];
    logic [63:0] id_count;
    int         size_reg[4];

    function automatic int region_cap(int r);
        if (r >= NUM_REGIONS_DEF) return 0;
        return (size_reg[r] > RGN_MAX) ? RGN_MAX : size_reg[r];
    endfunction

    function automatic int unallocated();
        int cap;
        int used;
        cap = 0;
        used = 0;
        for (int r = 0; r < 4; r++) cap += region_cap(r);
        for (int i = 0; i < SLOTS; i++) if (blk_valid[i]) used += blk_len[i];
        return (cap > used) ? cap - used : 0;
    endfunction

    function automatic bit span_clear(int r, int p, int len);
        if (p + len > region_cap(r)) return 0;
        for (int i = 0; i < SLOTS; i++)
            if (blk_valid[i] && blk_region[i] == r &&
                p < blk_start[i] + blk_len[i] && blk_start[i] < p + len)
                return 0;
        return 1;
    endfunction

    function automatic bit find_gap(int len, output int rgn, output int off);
        bit found;
        int lowest;
        int p;
        rgn = 0;
        off = 0;
        if (len == 0) return 0;
        for (int r = 0; r < 4; r++) begin
            found = 0;
            lowest = 0;
            if (region_cap(r) == 0) continue;
            if (span_clear(r, 0, len)) begin
                rgn = r;
                return 1;
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (!blk_valid[i] || blk_region[i] != r) continue;
                p = blk_start[i] + blk_len[i];
                if ((!found || p < lowest) && span_clear(r, p, len)) begin
                    found = 1;
                    lowest = p;
                end
            end
            if (found) begin
                rgn = r;
                off = lowest;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic int owned_block(logic [63:0] own, logic [63:0] thr);
        int hit;
        int lowest;
        int key;
        hit = -1;
        lowest = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!blk_valid[i] || blk_owner[i] != own || blk_thread[i] != thr) continue;
            key = (blk_region[i] << 17) | blk_start[i];
            if (hit < 0 || key < lowest) begin
                hit = i;
                lowest = key;
            end
        end
        return hit;
    endfunction

    function automatic logic [1:0] place_new(int len, logic [63:0] own, logic [63:0] thr,
                                             output int rgn, output int off);
        int s;
        s = -1;
        rgn = 0;
        off = 0;
        for (int i = SLOTS - 1; i >= 0; i--) if (!blk_valid[i]) s = i;
        if (s < 0 || !find_gap(len, rgn, off)) return STATUS_NO_SPACE;
        blk_valid[s]  = 1;
        blk_region[s] = rgn;
        blk_start[s]  = off;
        blk_len[s]    = len;
        blk_owner[s]  = own;
        blk_thread[s] = thr;
        return STATUS_OK;
    endfunction

    function automatic outcome_t apply_request(logic [1:0] op, int req,
                                               logic [63:0] own, logic [63:0] thr);
        outcome_t o;
        int m;
        int rgn;
        int off;
        int tail;
        int lim;
        o.st = STATUS_OK;
        o.ident = '0;
        rgn = 0;
        off = 0;
        case (op)
            OP_ALLOC: o.st = place_new(req, own, thr, rgn, off);
            OP_RELEASE: begin
                m = owned_block(own, thr);
                if (m < 0) o.st = STATUS_NO_MATCH;
                else blk_valid[m] = 0;
            end
            OP_GROW: begin
                m = owned_block(own, thr);
                if (m < 0) o.st = STATUS_NO_MATCH;
                else begin
                    tail = blk_start[m] + blk_len[m];
                    lim = region_cap(blk_region[m]);
                    for (int i = 0; i < SLOTS; i++)
                        if (blk_valid[i] && blk_region[i] == blk_region[m] &&
                            blk_start[i] > blk_start[m] && blk_start[i] < lim)
                            lim = blk_start[i];
                    if (req == 0 || tail + req <= lim) begin
                        blk_len[m] += req;
                        rgn = blk_region[m];
                        off = blk_start[m];
                    end else begin
                        o.st = place_new(blk_len[m] + req, own, thr, rgn, off);
                        if (o.st == STATUS_OK) blk_valid[m] = 0;
                    end
                end
            end
            default: begin
                id_count = id_count + 1;
                o.ident = id_count;
            end
        endcase
        if (o.st != STATUS_OK) begin
            rgn = 0;
            off = 0;
        end
        o.rgn = rgn[RGN_W-1:0];
        o.off = off[OFF_W-1:0];
        o.free = unallocated();
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n) begin
        outcome_t e;
        if (!rst_n) begin
            expected_q.delete();
            for (int i = 0; i < SLOTS; i++) blk_valid[i] = 0;
            id_count = '0;
            size_reg = '{RGN_MAX, 0, 0, 0};
            mismatches <= 0;
            results_seen <= 0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr >> 2) <= REG_SIZE_D)
                size_reg[paddr >> 2] = pwdata & 32'h1FFFF;
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("result transaction with none expected");
                    mismatches <= mismatches + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.st !== status || e.rgn !== block_region || e.off !== block_offset ||
                        e.ident !== new_identifier || e.free !== free_bytes)
                        mismatches <= mismatches + 1;
                    if (e.st !== status)
                        $error("status expected %0d actual %0d", e.st, status);
                    if (e.rgn !== block_region)
                        $error("block_region expected %0d actual %0d", e.rgn, block_region);
                    if (e.off !== block_offset)
                        $error("block_offset expected %0d actual %0d", e.off, block_offset);
                    if (e.ident !== new_identifier)
                        $error("new_identifier expected %0h actual %0h",
                               e.ident, new_identifier);
                    if (e.free !== free_bytes)
                        $error("free_bytes expected %0d actual %0d", e.free, free_bytes);
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(apply_request(opcode, int'(request_bytes),
                                                   owner_tag, thread_tag));
        end
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    import ffba_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [SIZE_W-1:0]  request_bytes;
    logic [TAG_W-1:0]   owner_tag;
    logic [TAG_W-1:0]   thread_tag;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [RGN_W-1:0]   block_region;
    logic [OFF_W-1:0]   block_offset;
    logic [TAG_W-1:0]   new_identifier;
    logic [FREE_W-1:0]  free_bytes;

    int          mismatches;
    int          pending;
    int          results_seen;
    int          idle_mode;
    int          requests_sent;
    int          size_writes;
    logic [63:0] owner_pool[4];
    logic [63:0] thread_pool[2];

    first_fit_block_allocator_core u_dut (.*);

    ffba_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        case (idle_mode)
            2:       out_ready <= ($urandom_range(0, 99) >= 83);
            3:       out_ready <= ($urandom_range(0, 99) >= 10);
            default: out_ready <= 1'b1;
        endcase
    end

    function automatic bit sender_holds();
        if (idle_mode == 1) return $urandom_range(0, 99) < 83;
        if (idle_mode == 3) return $urandom_range(0, 99) < 10;
        return 0;
    endfunction

    task automatic send(logic [1:0] op, int req, logic [63:0] own, logic [63:0] thr);
        while (sender_holds())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        request_bytes <= req[SIZE_W-1:0];
        owner_tag     <= own;
        thread_tag    <= thr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    task automatic write_size(logic [1:0] idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_writes++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regions(int a, int b, int c, int d);
        drain();
        write_size(REG_SIZE_A, a);
        write_size(REG_SIZE_B, b);
        write_size(REG_SIZE_C, c);
        write_size(REG_SIZE_D, d);
    endtask

    task automatic random_request();
        logic [1:0]  op;
        int          pick;
        int          req;
        logic [63:0] own;
        logic [63:0] thr;
        pick = $urandom_range(0, 99);
        op = (pick < 40) ? OP_ALLOC : (pick < 65) ? OP_RELEASE :
             (pick < 85) ? OP_GROW : OP_IDENT;
        pick = $urandom_range(0, 99);
        if (pick < 8) req = 0;
        else if (pick < 12) req = 65536;
        else if (pick < 20) req = $urandom_range(0, 65536);
        else req = $urandom_range(1, 3000);
        if ($urandom_range(0, 9) == 0)
        begin
            own = {$urandom, $urandom};
            thr = {$urandom, $urandom};
        end
        else
        begin
            own = owner_pool[$urandom_range(0, 3)];
            thr = thread_pool[$urandom_range(0, 1)];
        end
        send(op, req, own, thr);
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_valid = 0;
        opcode = OP_ALLOC;
        request_bytes = '0;
        owner_tag = '0;
        thread_tag = '0;
        out_ready = 1;
        idle_mode = 0;
        requests_sent = 0;
        size_writes = 0;
        foreach (owner_pool[i]) owner_pool[i] = {$urandom, $urandom};
        foreach (thread_pool[i]) thread_pool[i] = {$urandom, $urandom};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_ALLOC, 0, '0, '0);
        send(OP_RELEASE, 0, '0, '0);
        send(OP_GROW, 100, '0, '0);
        send(OP_IDENT, 0, '0, '0);
        send(OP_ALLOC, 65536, '1, '1);
        send(OP_ALLOC, 1, '0, '0);
        send(OP_GROW, 0, '1, '1);
        send(OP_GROW, 1, '1, '1);
        send(OP_RELEASE, 0, '1, '1);
        send(OP_ALLOC, 100, '0, '1);
        send(OP_ALLOC, 200, '1, '0);
        send(OP_GROW, 50, '0, '1);
        send(OP_RELEASE, 0, '1, '0);
        send(OP_GROW, 50, '0, '1);
        send(OP_GROW, 65536, '0, '1);
        send(OP_IDENT, 65536, '1, '1);
        set_regions(1, 65536, 0, 65536);
        send(OP_ALLOC, 1, '0, '0);
        send(OP_ALLOC, 65536, '1, '1);
        send(OP_ALLOC, 65536, '1, '1);
        send(OP_GROW, 65536, '1, '1);
        send(OP_ALLOC, 2, '0, '0);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_regions(65536, 0, 0, 0);
                1: set_regions(4000, 3000, 0, 2000);
                2: set_regions(1000, 500, 0, 0);
                3: set_regions(65536, 65536, 65536, 65536);
                4: set_regions(1, 0, 5000, 0);
                5: set_regions(3000, 3000, 3000, 3000);
                6: set_regions(0, 0, 0, 0);
                default: set_regions(20000, 0, 65536, 700);
            endcase
            idle_mode = phase % 4;
            for (int n = 0; n < 240; n++) random_request();
        end
        drain();

        $display("Sent %0d requests over 4 handshake idle modes and %0d region size writes.",
                 requests_sent, size_writes);
        $display("Checked %0d result transactions.", results_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
